FILE: sv/ntps_pkg.sv
// Shared constants and types for the nearest-target pursuit step block.
`default_nettype none
package ntps_pkg;
    localparam int MaxTargets = 256;
    localparam int CntW = $clog2(MaxTargets + 1);
    localparam int SlotW = (CntW > 8) ? CntW : 8;
    localparam int DistW = 34;
    localparam int OffW = 17;
    localparam int MagW = 25;   // floor(sqrt(D*2^16)) < 2^24.5
    localparam int NumW = 41;   // |d|*step*2^8 + m/2 < 2^41
    localparam int RootW = 50;  // radicand width, even

    localparam logic [1:0] CfgOriginX = 2'd0;
    localparam logic [1:0] CfgOriginY = 2'd1;
    localparam logic [1:0] CfgStep    = 2'd2;

    typedef struct packed {
        logic accum;      // fold current point into the running best
        logic clear;      // reset the run state
        logic sqrt_start;
        logic div_start;
        logic div_sel_y;
        logic cap_x;      // capture origin plus signed divider result, saturated, into new x
        logic cap_y;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic zero_dist;
    } t_stat;
endpackage
`default_nettype wire

FILE: sv/ntps_datapath.sv
// Datapath: offset, squared distance, running best, square root and divider.
`default_nettype none
module ntps_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ntps_pkg::t_cmd                i_cmd,
    output ntps_pkg::t_stat                    o_stat,
    input  wire logic signed [15:0]            i_tx,
    input  wire logic signed [15:0]            i_ty,
    input  wire logic signed [15:0]            i_org_x,
    input  wire logic signed [15:0]            i_org_y,
    input  wire logic        [15:0]            i_step,
    output logic             [7:0]             o_index,
    output logic             [ntps_pkg::DistW-1:0] o_dist,
    output logic signed      [15:0]            o_new_x,
    output logic signed      [15:0]            o_new_y
);
    logic [ntps_pkg::DistW-1:0] r_best;
    logic signed [ntps_pkg::OffW-1:0] r_bdx, r_bdy;
    logic [ntps_pkg::SlotW-1:0] r_slot;
    logic [ntps_pkg::CntW-1:0] r_cnt;

    logic signed [ntps_pkg::OffW-1:0] dx, dy;
    logic [ntps_pkg::OffW-1:0] ax, ay;
    logic [ntps_pkg::DistW-1:0] d;
    logic in_range;

    assign dx = ntps_pkg::OffW'(i_tx) - ntps_pkg::OffW'(i_org_x);
    assign dy = ntps_pkg::OffW'(i_ty) - ntps_pkg::OffW'(i_org_y);
    assign ax = dx[ntps_pkg::OffW-1] ? ntps_pkg::OffW'(-dx) : dx;
    assign ay = dy[ntps_pkg::OffW-1] ? ntps_pkg::OffW'(-dy) : dy;
    assign d = ntps_pkg::DistW'(ax * ax) + ntps_pkg::DistW'(ay * ay);
    assign in_range = (r_cnt < ntps_pkg::CntW'(ntps_pkg::MaxTargets));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_best <= '0;
            r_bdx <= '0;
            r_bdy <= '0;
            r_slot <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accum && in_range) begin
            if (r_cnt == '0 || d < r_best) begin
                r_best <= d;
                r_bdx <= dx;
                r_bdy <= dy;
                r_slot <= ntps_pkg::SlotW'(r_cnt);
            end
            r_cnt <= r_cnt + ntps_pkg::CntW'(1);
        end
    end

    // bit-pair square root, one step per cycle
    logic [ntps_pkg::RootW-1:0] r_rad;
    logic [ntps_pkg::MagW+1:0] r_rem;
    logic [ntps_pkg::MagW-1:0] r_root;
    logic [4:0] r_sq_cnt;
    logic r_sq_busy, r_sq_done;
    logic [ntps_pkg::MagW+1:0] trial, rem_sh;

    assign rem_sh = {r_rem[ntps_pkg::MagW-1:0], r_rad[ntps_pkg::RootW-1 -: 2]};
    assign trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_rad <= {r_best, 16'd0};
            r_rem <= '0;
            r_root <= '0;
            r_sq_cnt <= 5'(ntps_pkg::MagW - 1);
            r_sq_busy <= 1'b1;
            r_sq_done <= 1'b0;
        end else if (r_sq_busy) begin
            r_rad <= {r_rad[ntps_pkg::RootW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem <= rem_sh - trial;
                r_root <= {r_root[ntps_pkg::MagW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_root <= {r_root[ntps_pkg::MagW-2:0], 1'b0};
            end
            if (r_sq_cnt == '0) begin
                r_sq_busy <= 1'b0;
                r_sq_done <= 1'b1;
            end else begin
                r_sq_cnt <= r_sq_cnt - 5'd1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [ntps_pkg::NumW-1:0] r_num, r_quo;
    logic [ntps_pkg::MagW:0] r_drem;
    logic [5:0] r_dv_cnt;
    logic r_dv_busy, r_dv_done, r_neg;
    logic [ntps_pkg::OffW-1:0] sel_a;
    logic [32:0] prod;
    logic [ntps_pkg::NumW-1:0] num0;
    logic [ntps_pkg::MagW+1:0] drem_sh;

    assign sel_a = i_cmd.div_sel_y ? (r_bdy[ntps_pkg::OffW-1] ? ntps_pkg::OffW'(-r_bdy) : r_bdy)
                                   : (r_bdx[ntps_pkg::OffW-1] ? ntps_pkg::OffW'(-r_bdx) : r_bdx);
    assign prod = 33'(sel_a) * 33'(i_step);
    assign num0 = ntps_pkg::NumW'({prod, 8'd0}) + ntps_pkg::NumW'(r_root >> 1);
    assign drem_sh = {r_drem, r_num[ntps_pkg::NumW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_num <= num0;
            r_neg <= i_cmd.div_sel_y ? r_bdy[ntps_pkg::OffW-1] : r_bdx[ntps_pkg::OffW-1];
            r_drem <= '0;
            r_quo <= '0;
            r_dv_cnt <= 6'(ntps_pkg::NumW - 1);
            r_dv_busy <= 1'b1;
            r_dv_done <= 1'b0;
        end else if (r_dv_busy) begin
            r_num <= {r_num[ntps_pkg::NumW-2:0], 1'b0};
            if (drem_sh >= {1'b0, r_root}) begin
                r_drem <= (ntps_pkg::MagW+1)'(drem_sh - {1'b0, r_root});
                r_quo <= {r_quo[ntps_pkg::NumW-2:0], 1'b1};
            end else begin
                r_drem <= drem_sh[ntps_pkg::MagW:0];
                r_quo <= {r_quo[ntps_pkg::NumW-2:0], 1'b0};
            end
            if (r_dv_cnt == '0) begin
                r_dv_busy <= 1'b0;
                r_dv_done <= 1'b1;
            end else begin
                r_dv_cnt <= r_dv_cnt - 6'd1;
            end
        end
    end

    // signed add to origin with saturation
    logic signed [ntps_pkg::NumW+1:0] sum_x, mv;
    logic signed [15:0] sat_v;
    logic signed [ntps_pkg::NumW+1:0] org_sel;

    assign mv = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign org_sel = i_cmd.cap_y ? (ntps_pkg::NumW+2)'(i_org_y) : (ntps_pkg::NumW+2)'(i_org_x);
    assign sum_x = org_sel + mv;
    always_comb begin
        if (sum_x > 32767) sat_v = 16'sh7fff;
        else if (sum_x < -32768) sat_v = -16'sh8000;
        else sat_v = sum_x[15:0];
    end

    logic signed [15:0] r_nx, r_ny;
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_x) r_nx <= sat_v;
        if (i_cmd.cap_y) r_ny <= sat_v;
    end

    logic zero;
    assign zero = (r_best == '0);
    assign o_stat = '{sqrt_done: r_sq_done, div_done: r_dv_done, zero_dist: zero};
    assign o_index = r_slot[7:0];
    assign o_dist = r_best;
    assign o_new_x = zero ? i_org_x : r_nx;
    assign o_new_y = zero ? i_org_y : r_ny;
endmodule
`default_nettype wire

FILE: sv/ntps_ctrl.sv
// Controller: sequences accumulation, root, two divides and result hand-off.
`default_nettype none
module ntps_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_last,
    output logic                o_ready,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ntps_pkg::t_cmd      o_cmd,
    input  wire ntps_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_DIVX, S_DIVY, S_OUT} t_state;
    t_state r_state;
    logic r_started;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        o_cmd.accum = o_ready && i_valid;
        o_cmd.clear = o_valid && i_ready;
        o_cmd.div_sel_y = (r_state == S_DIVY);
        o_cmd.cap_x = (r_state == S_DIVX) && r_started && i_stat.div_done;
        o_cmd.cap_y = (r_state == S_DIVY) && r_started && i_stat.div_done;
        o_cmd.sqrt_start = (r_state == S_SQRT) && !r_started;
        o_cmd.div_start = ((r_state == S_SQRT) && r_started && i_stat.sqrt_done)
                       || ((r_state == S_DIVY) && !r_started);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid && i_last) begin
                    r_state <= S_SQRT;
                    r_started <= 1'b0;
                end
                S_SQRT: begin
                    // the root starts on entry to S_SQRT, once the last point is folded into the best
                    if (!r_started) r_started <= 1'b1;
                    else if (i_stat.zero_dist) r_state <= S_OUT;
                    else if (i_stat.sqrt_done) begin
                        r_state <= S_DIVX;
                        r_started <= 1'b0;
                    end
                end
                S_DIVX: begin
                    if (!r_started) r_started <= 1'b1;
                    else if (i_stat.div_done) begin
                        r_state <= S_DIVY;
                        r_started <= 1'b0;
                    end
                end
                S_DIVY: begin
                    if (!r_started) r_started <= 1'b1;
                    else if (i_stat.div_done) r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/nearest_target_pursuit_step.sv
// Top level: nearest-target search with one normalized seek step.
`default_nettype none
// Points stream in one per cycle while the block is idle and are folded into
// the running nearest in that cycle. The last point of a run starts a bit-pair
// square root and two restoring divides (one per axis), and no input is taken
// until the result is taken. A zero nearest distance skips the divides and
// returns the origin with moved = 0.
module nearest_target_pursuit_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // target_x, target_y
    input  wire logic        s_axis_tlast,  // last_target
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // nearest_index, nearest_dist_sq, new_x, new_y, moved
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic signed [15:0] r_org_x, r_org_y;
    logic [15:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_step <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ntps_pkg::CfgOriginX: r_org_x <= i_cfg_data;
                ntps_pkg::CfgOriginY: r_org_y <= i_cfg_data;
                ntps_pkg::CfgStep:    r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ntps_pkg::t_cmd cmd;
    ntps_pkg::t_stat stat;
    logic [7:0] idx;
    logic [ntps_pkg::DistW-1:0] best_dist;
    logic signed [15:0] nx, ny;

    ntps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_last(s_axis_tlast), .o_ready(s_axis_tready),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_cmd(cmd), .i_stat(stat)
    );

    ntps_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_tx(s_axis_tdata[15:0]), .i_ty(s_axis_tdata[31:16]),
        .i_org_x(r_org_x), .i_org_y(r_org_y), .i_step(r_step),
        .o_index(idx), .o_dist(best_dist), .o_new_x(nx), .o_new_y(ny)
    );

    assign m_axis_tdata = {5'd0, !stat.zero_dist, ny, nx, best_dist, idx};
endmodule
`default_nettype wire

FILE: tb/nearest_target_pursuit_step_tb.sv
// Testbench for the nearest-target pursuit step: directed and random point runs.
`default_nettype none
module nearest_target_pursuit_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        moved;
        logic [15:0] new_y;
        logic [15:0] new_x;
        logic [33:0] dist_sq;
        logic [7:0]  index;
    } t_seek;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [79:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = ntps_pkg::CfgOriginX;
    logic [15:0] i_cfg_data = '0;

    nearest_target_pursuit_step u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Seeker model state
    logic signed [15:0] org_x, org_y;
    logic        [15:0] step_len;
    logic        [33:0] best_d;
    logic signed [16:0] best_dx, best_dy;
    int unsigned        best_slot, pt_count;
    t_seek              seek_q[$];

    int  errors = 0;
    int  snd_idle = 12, rcv_idle = 73;
    bit  rcv_hold = 1'b0;
    longint cycles = 0;

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic longint step_comp(logic signed [16:0] d, logic [63:0] mag);
        longint unsigned a, q;
        a = (d < 0) ? -longint'(d) : longint'(d);
        q = ((a * step_len) << 8) + (mag >> 1);
        q = q / mag;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_point(logic [15:0] tx, logic [15:0] ty, logic last);
        logic signed [16:0] dx, dy;
        logic [33:0] d;
        logic [63:0] mag;
        t_seek r;
        if (pt_count < ntps_pkg::MaxTargets) begin
            dx = $signed(tx) - org_x;
            dy = $signed(ty) - org_y;
            d = 34'(dx * dx) + 34'(dy * dy);
            if (pt_count == 0 || d < best_d) begin
                best_d = d; best_dx = dx; best_dy = dy; best_slot = pt_count;
            end
            pt_count++;
        end
        if (!last) return;
        r.index = best_slot[7:0];
        r.dist_sq = best_d;
        if (best_d == 0) begin
            r.new_x = org_x; r.new_y = org_y; r.moved = 1'b0;
        end else begin
            mag = isqrt(64'(best_d) << 16);
            r.new_x = clamp16(longint'(org_x) + step_comp(best_dx, mag));
            r.new_y = clamp16(longint'(org_y) + step_comp(best_dy, mag));
            r.moved = 1'b1;
        end
        seek_q.push_back(r);
        best_d = 0; best_dx = 0; best_dy = 0; best_slot = 0; pt_count = 0;
    endtask

    // leaves tvalid high after the accepting edge; later code drops it when idle
    task automatic send_point(logic [15:0] tx, logic [15:0] ty, logic last);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ty, tx};
        s_axis_tlast <= last;
        predict_point(tx, ty, last);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (seek_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            ntps_pkg::CfgOriginX: org_x = val;
            ntps_pkg::CfgOriginY: org_y = val;
            default:              step_len = val;
        endcase
    endtask

    task automatic set_seeker(logic [15:0] x, logic [15:0] y, logic [15:0] s);
        wait_idle();
        write_cfg(ntps_pkg::CfgOriginX, x);
        write_cfg(ntps_pkg::CfgOriginY, y);
        write_cfg(ntps_pkg::CfgStep, s);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        t_seek got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[74:0];
            if (seek_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                exp_r = seek_q.pop_front();
                if (got.index !== exp_r.index) begin
                    $error("nearest_index exp %0d got %0d", exp_r.index, got.index); errors++;
                end
                if (got.dist_sq !== exp_r.dist_sq) begin
                    $error("nearest_dist_sq exp %0d got %0d", exp_r.dist_sq, got.dist_sq);
                    errors++;
                end
                if (got.new_x !== exp_r.new_x) begin
                    $error("new_x exp %h got %h", exp_r.new_x, got.new_x); errors++;
                end
                if (got.new_y !== exp_r.new_y) begin
                    $error("new_y exp %h got %h", exp_r.new_y, got.new_y); errors++;
                end
                if (got.moved !== exp_r.moved) begin
                    $error("moved exp %0d got %0d", exp_r.moved, got.moved); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        set_seeker(16'h0000, 16'h0000, 16'h0010);
        send_point(16'h0000, 16'h0000, 1'b1);              // zero distance
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h0030, 16'h0040, 1'b1);
        send_point(16'h0010, 16'h0000, 1'b0);              // tie: first wins
        send_point(16'h0000, 16'h0010, 1'b0);
        send_point(16'hFFF0, 16'h0000, 1'b1);
        set_seeker(16'h7FFF, 16'h8000, 16'hFFFF);
        send_point(16'h8000, 16'h7FFF, 1'b1);              // extreme offsets
        send_point(16'h7FFF, 16'h7FFF, 1'b1);
        set_seeker(16'h7FF0, 16'h0000, 16'hFFFF);
        send_point(16'h7FFF, 16'h0001, 1'b1);              // saturate
        set_seeker(16'h8000, 16'h8000, 16'h0000);
        send_point(16'h1234, 16'hABCD, 1'b1);              // zero step
        set_seeker(16'h0100, 16'hFF00, 16'h0123);
        send_point(16'h0100, 16'hFF00, 1'b0);
        send_point(16'h0200, 16'h0300, 1'b1);
    endtask

    task automatic test_long_run();
        // more than MaxTargets points; later ones are ignored
        set_seeker(16'h0000, 16'h0000, 16'h0040);
        for (int i = 0; i < ntps_pkg::MaxTargets + 20; i++)
            send_point((i == ntps_pkg::MaxTargets + 5) ? 16'h0000 : 16'(1000 - i),
                       16'($urandom_range(50, 200)), i == ntps_pkg::MaxTargets + 19);
    endtask

    task automatic test_random(int n_items);
        int left;
        left = n_items;
        while (left > 0) begin
            int len;
            logic [15:0] base_x, base_y;
            set_seeker(16'($urandom), 16'($urandom),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512)));
            len = $urandom_range(1, 12);
            base_x = 16'($urandom); base_y = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                logic [15:0] tx, ty;
                case ($urandom_range(3))
                    0: begin tx = 16'($urandom); ty = 16'($urandom); end
                    1: begin tx = org_x + 16'($urandom_range(64)) - 16'd32;
                             ty = org_y + 16'($urandom_range(64)) - 16'd32; end
                    2: begin tx = base_x; ty = base_y; end
                    default: begin tx = base_x ^ 16'($urandom_range(3));
                                   ty = base_y; end
                endcase
                send_point(tx, ty, i == len - 1);
            end
            left -= len;
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rcv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rcv_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_point(16'($urandom), 16'($urandom), i % 3 == 2);
                s_axis_tvalid <= 1'b0;
            end
        join
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        org_x = 0; org_y = 0; step_len = 0;
        best_d = 0; best_dx = 0; best_dy = 0; best_slot = 0; pt_count = 0;
        test_directed();
        test_long_run();
        test_random(200);
        snd_idle = 73; rcv_idle = 12;
        test_backpressure();
        test_random(200);
        snd_idle = 0; rcv_idle = 0;
        test_random(200);
        wait_idle();
        if (errors == 0 && seek_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
sv/ntps_pkg.sv
sv/ntps_datapath.sv
sv/ntps_ctrl.sv
sv/nearest_target_pursuit_step.sv
tb/nearest_target_pursuit_step_tb.sv
